[rtl/core/assert_macros.svh]
// assertion helpers shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the core clock, off while reset is asserted
`define PNGUNF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition now implies consequence on the following cycle
`define PNGUNF_ASSERT_NEXT(label, pre, post, msg) \
  `PNGUNF_ASSERT(label, (pre) |=> (post), msg)

`endif

[rtl/core/pngunf_pkg.sv]
package pngunf_pkg;

  // default sizing of the core
  localparam int unsigned MaxRowBytesDef   = 32768;
  localparam int unsigned MaxPixelBytesDef = 8;
  localparam int unsigned MaxRowsDef       = 4096;

  // field widths of the configuration registers and the byte stream
  localparam int unsigned RowLengthW  = 16;
  localparam int unsigned PixelBytesW = 4;
  localparam int unsigned ImageRowsW  = 13;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned ByteW       = 8;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegRowLength  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegPixelBytes = 2'd1;
  localparam logic [CfgIndexW-1:0] RegImageRows  = 2'd2;

  // largest legal filter type code
  localparam logic [ByteW-1:0] MaxFilterCode = 8'd4;

  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltAvg   = 3'd3,
    FiltPaeth = 3'd4
  } filter_e;

  // decoded control for one transaction waiting in the work register
  typedef struct packed {
    logic    is_data;
    logic    emit;
    logic    bad;
    logic    last;
    logic    has_left;
    logic    has_up;
    filter_e filter;
  } work_ctrl_t;

endpackage

[rtl/core/pngunf_ram.sv]
module pngunf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/png_scanline_unfilter_core.sv]
// PNG scanline unfilter core. Takes the inflated stream one byte per transaction: every
// row is a filter type byte followed by row_length data bytes, and each data byte comes
// out rebuilt with None, Sub, Up, Average or Paeth, one result byte per data byte, tlast
// on the last byte of each row. Filter bytes give no result, except a type above 4, which
// gives a single result with tuser set and zero data; the rest of that image is then
// swallowed until image_rows rows have passed. One byte is accepted every cycle unless the
// result side stalls; each byte goes through the work register, where its line store read
// data arrives, and then the result register. The line store is a single block RAM with
// one write and one registered read per cycle, and it needs no clearing after reset.
// Configuration may be written between transactions; new values apply from the next
// byte on. Out of range register values are clamped to 1..maximum.
`include "assert_macros.svh"

module png_scanline_unfilter_core #(
  parameter int unsigned MaxRowBytes   = pngunf_pkg::MaxRowBytesDef,
  parameter int unsigned MaxPixelBytes = pngunf_pkg::MaxPixelBytesDef,
  parameter int unsigned MaxRows       = pngunf_pkg::MaxRowsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [pngunf_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [pngunf_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [pngunf_pkg::ByteW-1:0]        s_axis_tdata_i,   // [7:0] data_byte
  // reconstructed stream out
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [pngunf_pkg::ByteW-1:0]        m_axis_tdata_o,   // [7:0] pixel_byte
  output logic                                m_axis_tlast_o,   // row_end
  output logic                                m_axis_tuser_o    // [0] bad_filter
);

  import pngunf_pkg::*;

  localparam int unsigned LenW   = $clog2(MaxRowBytes + 1);
  localparam int unsigned AddrW  = $clog2(MaxRowBytes);
  localparam int unsigned SlotW  = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;
  localparam int unsigned PbW    = $clog2(MaxPixelBytes + 1);
  localparam int unsigned RowW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned RowsW  = $clog2(MaxRows + 1);
  localparam int unsigned CmpW   = (LenW > PbW) ? LenW : PbW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [RowLengthW-1:0]  row_length_q;
  logic [PixelBytesW-1:0] pixel_bytes_q;
  logic [ImageRowsW-1:0]  image_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= RowLengthW'(1);
      pixel_bytes_q <= PixelBytesW'(1);
      image_rows_q  <= ImageRowsW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRowLength:  row_length_q  <= cfg_wdata_i[RowLengthW-1:0];
        RegPixelBytes: pixel_bytes_q <= cfg_wdata_i[PixelBytesW-1:0];
        RegImageRows:  image_rows_q  <= cfg_wdata_i[ImageRowsW-1:0];
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // clamped working values
  logic [LenW-1:0]  len_c;
  logic [PbW-1:0]   pb_c;
  logic [RowsW-1:0] rows_c;

  always_comb begin
    if (row_length_q == '0) begin
      len_c = LenW'(1);
    end else if (17'(row_length_q) > 17'(MaxRowBytes)) begin
      len_c = LenW'(MaxRowBytes);
    end else begin
      len_c = LenW'(row_length_q);
    end

    if (pixel_bytes_q == '0) begin
      pb_c = PbW'(1);
    end else if (pixel_bytes_q > PixelBytesW'(MaxPixelBytes)) begin
      pb_c = PbW'(MaxPixelBytes);
    end else begin
      pb_c = PbW'(pixel_bytes_q);
    end

    if (image_rows_q == '0) begin
      rows_c = RowsW'(1);
    end else if (17'(image_rows_q) > 17'(MaxRows)) begin
      rows_c = RowsW'(MaxRows);
    end else begin
      rows_c = RowsW'(image_rows_q);
    end
  end

  // ---------------------------------------------------------------------------
  // front end: row / byte position tracking at input accept
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic             expect_filter_q, expect_filter_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [RowW-1:0]  row_q, row_d;
  filter_e          filter_q, filter_d;
  logic             err_q, err_d;
  // one position-modulo counter per possible pixel width
  logic [SlotW-1:0] slot_cnt_q [MaxPixelBytes];
  logic [SlotW-1:0] slot_cnt_d [MaxPixelBytes];

  work_ctrl_t       ctrl_d;
  logic [SlotW-1:0] slot_sel;
  logic             last_c;
  logic             row_wrap_c;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_sel = slot_cnt_q[SlotW'(pb_c - PbW'(1))];
  assign last_c   = ((LenW + 1)'(pos_q) + (LenW + 1)'(1)) >= (LenW + 1)'(len_c);
  assign row_wrap_c = ((RowsW + 1)'(row_q) + (RowsW + 1)'(1)) >= (RowsW + 1)'(rows_c);

  always_comb begin
    expect_filter_d = expect_filter_q;
    pos_d           = pos_q;
    row_d           = row_q;
    filter_d        = filter_q;
    err_d           = err_q;
    slot_cnt_d      = slot_cnt_q;

    ctrl_d          = '0;
    ctrl_d.filter   = filter_q;

    if (expect_filter_q) begin
      // filter type byte
      expect_filter_d = 1'b0;
      if (!err_q) begin
        if (s_axis_tdata_i > MaxFilterCode) begin
          err_d       = 1'b1;
          filter_d    = FiltNone;
          ctrl_d.emit = 1'b1;
          ctrl_d.bad  = 1'b1;
        end else begin
          filter_d = filter_e'(s_axis_tdata_i[2:0]);
        end
      end
    end else begin
      // filtered data byte
      ctrl_d.is_data  = 1'b1;
      ctrl_d.emit     = !err_q;
      ctrl_d.last     = last_c;
      ctrl_d.has_left = CmpW'(pos_q) >= CmpW'(pb_c);
      ctrl_d.has_up   = (row_q != '0);
      if (last_c) begin
        expect_filter_d = 1'b1;
        pos_d           = '0;
        for (int k = 0; k < MaxPixelBytes; k++) begin
          slot_cnt_d[k] = '0;
        end
        if (row_wrap_c) begin
          row_d = '0;
          err_d = 1'b0;  // image done, error state clears
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        pos_d = pos_q + LenW'(1);
        for (int k = 0; k < MaxPixelBytes; k++) begin
          slot_cnt_d[k] = (slot_cnt_q[k] == SlotW'(k)) ? '0 : slot_cnt_q[k] + SlotW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_filter_q <= 1'b1;
      pos_q           <= '0;
      row_q           <= '0;
      filter_q        <= FiltNone;
      err_q           <= 1'b0;
      for (int k = 0; k < MaxPixelBytes; k++) begin
        slot_cnt_q[k] <= '0;
      end
    end else if (in_acc) begin
      expect_filter_q <= expect_filter_d;
      pos_q           <= pos_d;
      row_q           <= row_d;
      filter_q        <= filter_d;
      err_q           <= err_d;
      slot_cnt_q      <= slot_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // work register, aligned with the line store read data
  // ---------------------------------------------------------------------------
  logic             work_valid_q;
  work_ctrl_t       work_ctrl_q;
  logic [ByteW-1:0] work_x_q;
  logic [SlotW-1:0] work_slot_q;
  logic [AddrW-1:0] work_addr_q;
  logic             work_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      work_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      work_ctrl_q <= ctrl_d;
      work_x_q    <= s_axis_tdata_i;
      work_slot_q <= slot_sel;
      work_addr_q <= pos_q[AddrW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // line store: previous row, read at accept, written when the byte is rebuilt
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] up_rdata;
  logic [ByteW-1:0] recon;
  logic             hist_we;

  assign hist_we = work_fire && work_ctrl_q.is_data;

  pngunf_ram #(
    .Width (ByteW),
    .Depth (MaxRowBytes)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (work_addr_q),
    .wdata_i (recon),
    .re_i    (in_acc && !expect_filter_q),
    .raddr_i (pos_q[AddrW-1:0]),
    .rdata_o (up_rdata)
  );

  // ---------------------------------------------------------------------------
  // reconstruction
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] left_q [MaxPixelBytes];
  logic [ByteW-1:0] upleft_q [MaxPixelBytes];
  logic [ByteW-1:0] nb_a, nb_b, nb_c;
  logic [ByteW-1:0] pred;
  logic [ByteW:0]   avg_sum;
  logic signed [ByteW+1:0] d_pa, d_pb, d_pc;
  logic [ByteW+1:0] abs_pa, abs_pb, abs_pc;

  always_comb begin
    nb_a = work_ctrl_q.has_left ? left_q[work_slot_q] : '0;
    nb_b = work_ctrl_q.has_up ? up_rdata : '0;
    nb_c = (work_ctrl_q.has_left && work_ctrl_q.has_up) ? upleft_q[work_slot_q] : '0;

    avg_sum = (ByteW + 1)'(nb_a) + (ByteW + 1)'(nb_b);

    // paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    d_pa = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
    d_pb = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
    d_pc = $signed({2'b00, nb_a}) + $signed({2'b00, nb_b})
         - $signed({1'b0, nb_c, 1'b0});
    abs_pa = d_pa[ByteW+1] ? (ByteW + 2)'(-d_pa) : (ByteW + 2)'(d_pa);
    abs_pb = d_pb[ByteW+1] ? (ByteW + 2)'(-d_pb) : (ByteW + 2)'(d_pb);
    abs_pc = d_pc[ByteW+1] ? (ByteW + 2)'(-d_pc) : (ByteW + 2)'(d_pc);

    case (work_ctrl_q.filter)
      FiltSub:  pred = nb_a;
      FiltUp:   pred = nb_b;
      FiltAvg:  pred = avg_sum[ByteW:1];
      FiltPaeth: begin
        if (abs_pa <= abs_pb && abs_pa <= abs_pc) begin
          pred = nb_a;
        end else if (abs_pb <= abs_pc) begin
          pred = nb_b;
        end else begin
          pred = nb_c;
        end
      end
      default:  pred = '0;
    endcase

    recon = work_x_q + pred;
  end

  // left / upper-left history rings, one entry per byte of a pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPixelBytes; k++) begin
        left_q[k]   <= '0;
        upleft_q[k] <= '0;
      end
    end else if (hist_we) begin
      left_q[work_slot_q]   <= recon;
      upleft_q[work_slot_q] <= nb_b;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [ByteW-1:0] out_pixel_q;
  logic             out_last_q;
  logic             out_bad_q;

  // silent transactions retire without waiting on the output side
  assign work_fire = work_valid_q &&
                     (!work_ctrl_q.emit || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !work_valid_q || work_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (work_fire && work_ctrl_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_fire && work_ctrl_q.emit) begin
      out_pixel_q <= work_ctrl_q.bad ? '0 : recon;
      out_last_q  <= work_ctrl_q.bad ? 1'b0 : work_ctrl_q.last;
      out_bad_q   <= work_ctrl_q.bad;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pixel_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_bad_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PNGUNF_ASSERT(bad_result_clean_a, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0 && !m_axis_tlast_o, "error result carries data or row end")
  `PNGUNF_ASSERT_NEXT(accept_loads_work_a, in_acc, work_valid_q, "accepted transaction lost before the work register")
  `PNGUNF_ASSERT_NEXT(work_holds_a, work_valid_q && !work_fire, work_valid_q && $stable(work_x_q), "stalled work register changed")

endmodule

[tb/png_unfilter_checker.sv]
`timescale 1ns / 1ps

module png_unfilter_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pngunf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pngunf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [pngunf_pkg::ByteW-1:0]     in_data_i,    // [7:0] data_byte
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [pngunf_pkg::ByteW-1:0]     out_data_i,   // [7:0] pixel_byte
  input  logic                             out_last_i,   // row_end
  input  logic                             out_user_i,   // [0] bad_filter
  output int                               fail_count_o,
  output int                               pending_o
);

  import pngunf_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic             row_end;
    logic             bad;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];
  pixel_result_t oldest;

  logic [RowLengthW-1:0]  row_length_q;
  logic [PixelBytesW-1:0] pixel_bytes_q;
  logic [ImageRowsW-1:0]  image_rows_q;

  logic [ByteW-1:0] prev_row     [MaxRowBytesDef];
  logic [ByteW-1:0] left_ring    [MaxPixelBytesDef];
  logic [ByteW-1:0] up_left_ring [MaxPixelBytesDef];
  int unsigned      bytes_in_row;   // 0 while the filter byte is due
  int unsigned      row_in_image;
  filter_e          row_filter;
  logic             swallowing;     // rest of the image dropped after a bad filter

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ByteW-1:0] paeth_pick(logic [ByteW-1:0] a, logic [ByteW-1:0] b,
                                                  logic [ByteW-1:0] c);
    int est, da, db, dc;
    est = int'(a) + int'(b) - int'(c);
    da  = (est > int'(a)) ? est - int'(a) : int'(a) - est;
    db  = (est > int'(b)) ? est - int'(b) : int'(b) - est;
    dc  = (est > int'(c)) ? est - int'(c) : int'(c) - est;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] unfilter mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic unfilter_byte(input logic [ByteW-1:0] x);
    int unsigned      len, span, pos, slot;
    logic             has_left, has_up, last;
    logic [ByteW-1:0] a, b, c, pred, r;
    len  = clamp_reg(32'(row_length_q), MaxRowBytesDef);
    span = clamp_reg(32'(pixel_bytes_q), MaxPixelBytesDef);
    if (bytes_in_row == 0) begin
      bytes_in_row = 1;
      if (!swallowing) begin
        if (x > MaxFilterCode) begin
          swallowing = 1'b1;
          row_filter = FiltNone;
          expected_pixels.push_back('{pixel: '0, row_end: 1'b0, bad: 1'b1});
        end else begin
          row_filter = filter_e'(x[2:0]);
        end
      end
    end else begin
      pos      = bytes_in_row - 1;
      slot     = pos % span;
      has_left = (pos >= span);
      has_up   = (row_in_image != 0);
      a = has_left ? left_ring[slot] : '0;
      b = has_up ? prev_row[pos] : '0;
      c = (has_left && has_up) ? up_left_ring[slot] : '0;
      case (row_filter)
        FiltSub:   pred = a;
        FiltUp:    pred = b;
        FiltAvg:   pred = ByteW'((9'(a) + 9'(b)) >> 1);
        FiltPaeth: pred = paeth_pick(a, b, c);
        default:   pred = '0;
      endcase
      r = x + pred;
      up_left_ring[slot] = b;
      left_ring[slot]    = r;
      prev_row[pos]      = r;
      bytes_in_row++;
      last = ((bytes_in_row - 1) >= len);
      if (!swallowing) expected_pixels.push_back('{pixel: r, row_end: last, bad: 1'b0});
      if (last) begin
        bytes_in_row = 0;
        row_in_image++;
        if (row_in_image >= clamp_reg(32'(image_rows_q), MaxRowsDef)) begin
          row_in_image = 0;
          swallowing   = 1'b0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  = RowLengthW'(1);
      pixel_bytes_q = PixelBytesW'(1);
      image_rows_q  = ImageRowsW'(1);
      bytes_in_row  = 0;
      row_in_image  = 0;
      row_filter    = FiltNone;
      swallowing    = 1'b0;
      for (int i = 0; i < MaxPixelBytesDef; i++) begin
        left_ring[i]    = '0;
        up_left_ring[i] = '0;
      end
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegRowLength:  row_length_q  = cfg_wdata_i[RowLengthW-1:0];
          RegPixelBytes: pixel_bytes_q = cfg_wdata_i[PixelBytesW-1:0];
          RegImageRows:  image_rows_q  = cfg_wdata_i[ImageRowsW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i === 1'b1) unfilter_byte(in_data_i);
      if (out_valid_i === 1'b1 && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %02h with nothing pending", out_data_i));
        end else begin
          oldest = expected_pixels.pop_front();
          if (out_data_i !== oldest.pixel)
            report_mismatch($sformatf("pixel_byte %02h, want %02h", out_data_i, oldest.pixel));
          if (out_last_i !== oldest.row_end)
            report_mismatch($sformatf("row_end %b, want %b", out_last_i, oldest.row_end));
          if (out_user_i !== oldest.bad)
            report_mismatch($sformatf("bad_filter %b, want %b", out_user_i, oldest.bad));
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

[tb/png_scanline_unfilter_core_test.sv]
`timescale 1ns / 1ps

module png_scanline_unfilter_core_test;
  import pngunf_pkg::*;

  localparam int unsigned StallLimit   = 2000;  // cycles without any transaction
  localparam int unsigned RandomItems  = 380;
  localparam int unsigned SettleCycles = 6;     // pipeline depth plus margin

  typedef enum logic [1:0] {
    PaceFree,
    PaceSendIdle,
    PaceRecvStall,
    PaceBoth
  } pace_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = RegRowLength;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [ByteW-1:0]     in_byte   = '0;
  logic                 out_ready = 1'b0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [ByteW-1:0]     out_byte;
  wire                  out_last;
  wire                  out_bad;

  int          fail_count;
  int          pending_count;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  // sender's own view of where the stream stands, so that config writes never
  // make the block read a line store entry that was never written
  int unsigned len_reg      = 1;
  int unsigned rows_reg     = 1;
  int unsigned row_pos      = 0;  // 0 while the filter byte is due
  int unsigned row_num      = 0;
  int unsigned store_filled = 0;  // entries below this have been written
  int unsigned random_sent  = 0;
  bit          counting     = 1'b0;

  png_scanline_unfilter_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),    // [7:0] data_byte
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_byte),   // [7:0] pixel_byte
    .m_axis_tlast_o  (out_last),   // row_end
    .m_axis_tuser_o  (out_bad)     // [0] bad_filter
  );

  png_unfilter_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_byte),
    .out_last_i   (out_last),
    .out_user_i   (out_bad),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // watchdog: run of cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic set_pace(input pace_e p);
    case (p)
      PaceFree:      begin send_idle_pct = 0;  stall_pct = 0;  end
      PaceSendIdle:  begin send_idle_pct = 47; stall_pct = 0;  end
      PaceRecvStall: begin send_idle_pct = 0;  stall_pct = 47; end
      default:       begin send_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  // mostly legal filter types, now and then a bad one to break the image
  function automatic logic [ByteW-1:0] pick_filter();
    if ($urandom_range(0, 99) < 90) return ByteW'($urandom_range(int'(FiltNone), int'(FiltPaeth)));
    return ByteW'($urandom_range(int'(MaxFilterCode) + 1, 255));
  endfunction

  // data bytes with the extremes turning up often
  function automatic logic [ByteW-1:0] pick_data();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // one byte transaction; called and left at a falling edge, valid stays high
  // between back-to-back bytes
  task automatic push_stream_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    if (counting) random_sent++;
    // follow the row and image counters
    if (row_pos == 0) begin
      row_pos = 1;
    end else begin
      if (row_pos > store_filled) store_filled = row_pos;
      row_pos++;
      if (row_pos - 1 >= clamp_to(len_reg, MaxRowBytesDef)) begin
        row_pos = 0;
        row_num++;
        if (row_num >= clamp_to(rows_reg, MaxRowsDef)) row_num = 0;
      end
    end
  endtask

  // stop sending and wait until every result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one register write; the caller lowers the enable after a batch
  task automatic program_reg(input logic [CfgIndexW-1:0] idx, input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(v);
    @(negedge clk);
    case (idx)
      RegRowLength: len_reg  = v & ((1 << RowLengthW) - 1);
      RegImageRows: rows_reg = v & ((1 << ImageRowsW) - 1);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned len, input int unsigned span,
                           input int unsigned rows);
    settle();
    program_reg(RegRowLength, len);
    program_reg(RegPixelBytes, span);
    program_reg(RegImageRows, rows);
    cfg_we <= 1'b0;
  endtask

  // one whole image of random rows; optionally retune a register part way through
  task automatic run_image(input bit allow_retune);
    logic [CfgIndexW-1:0] idx;
    do begin
      if (row_pos == 0) push_stream_byte(pick_filter());
      else push_stream_byte(pick_data());
      if (allow_retune && $urandom_range(0, 59) == 0) begin
        settle();
        idx = CfgIndexW'($urandom_range(int'(RegRowLength), int'(RegImageRows)));
        case (idx)
          // past the first row a longer row would read stale line store entries
          RegRowLength:
            program_reg(idx, (row_num == 0) ? $urandom_range(0, 12)
                                            : $urandom_range(0, store_filled));
          RegPixelBytes: program_reg(idx, $urandom_range(0, (1 << PixelBytesW) - 1));
          default:       program_reg(idx, $urandom_range(0, 6));
        endcase
        cfg_we <= 1'b0;
      end
    end while (row_pos != 0 || row_num != 0);
  endtask

  initial begin
    int unsigned lap;
    set_pace(PaceFree);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: one byte per row, one row per image
    push_stream_byte(ByteW'(FiltNone));
    push_stream_byte(8'h00);
    push_stream_byte(ByteW'(FiltSub));
    push_stream_byte(8'hFF);
    // lowest bad type, then the highest; each swallows the rest of its image
    push_stream_byte(MaxFilterCode + 8'd1);
    push_stream_byte(8'h12);
    push_stream_byte(8'hFF);
    push_stream_byte(8'h34);

    // short rows over three lines so up, average and paeth see real neighbours
    configure(2, 1, 3);
    push_stream_byte(ByteW'(FiltUp));
    push_stream_byte(8'hFF);
    push_stream_byte(8'h01);
    push_stream_byte(ByteW'(FiltAvg));
    push_stream_byte(8'h80);
    push_stream_byte(8'h7F);
    push_stream_byte(ByteW'(FiltPaeth));
    push_stream_byte(8'hFF);
    push_stream_byte(8'h00);
    // bad filter in the middle of an image drops the remaining rows
    push_stream_byte(ByteW'(FiltNone));
    push_stream_byte(8'h10);
    push_stream_byte(8'h20);
    push_stream_byte(8'h07);
    push_stream_byte(8'h55);
    push_stream_byte(8'hAA);
    push_stream_byte(ByteW'(FiltSub));
    push_stream_byte(8'h01);
    push_stream_byte(8'h02);

    // random images on small settings, out of range values included, pacing
    // cycling through all modes
    lap      = 0;
    counting = 1'b1;
    while (random_sent < RandomItems) begin
      set_pace(pace_e'(lap % 4));
      configure($urandom_range(0, 12), $urandom_range(0, 9), $urandom_range(0, 5));
      repeat ($urandom_range(1, 3)) run_image(1'b1);
      lap++;
    end
    counting = 1'b0;

    // pixel width extremes on short images: the largest code clamped down to
    // the widest pixel, then the widest pixel itself on a single row
    set_pace(PaceBoth);
    configure(12, (1 << PixelBytesW) - 1, 2);
    run_image(1'b0);
    set_pace(PaceRecvStall);
    configure(10, MaxPixelBytesDef, 1);
    run_image(1'b0);

    // drain and give stray results a chance to show up
    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
